/* src/lz78_pkg.sv */
// lz78_pkg: shared types and fixed widths for the lz78 encoder
// no dependencies
`default_nettype none
package lz78_pkg;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 16;
  localparam int LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
  } out_item_t;
endpackage
`default_nettype wire

/* src/lz78_encoder.sv */
// lz78_encoder: lz78 phrase encoder with self-emptying dictionary
// depends on lz78_pkg
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | lz78_pkg::in_item_t
// out     | out | out_valid/out_stall| lz78_pkg::out_item_t
// cfg     | in  | cfg_we             | cfg_wdata (dict_limit)
//
// an item goes from idle through a read and a compare per dictionary entry probed (up to
// the entry count) to finish; the phrase memory reads and compares one entry at a time.
// the finishing cycle waits while a previous result is still stalled.
// reset clears count, prefix and output valid and sets the limit to LIMIT_RESET; the memory needs no clearing.
`default_nettype none
module lz78_encoder #(
  parameter int MAX_ENTRIES = 4096
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire lz78_pkg::in_item_t      in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output lz78_pkg::out_item_t          out_data,
  input  wire                          cfg_we,
  input  wire [lz78_pkg::LIMIT_W-1:0]  cfg_wdata
);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int XW = 18;
  localparam logic [XW-1:0] MAXX = XW'(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] prefix_r, prefix_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [lz78_pkg::LIMIT_W-1:0] limit_r;
  lz78_pkg::in_item_t  item_r;
  lz78_pkg::out_item_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CW+lz78_pkg::BYTE_W-1:0] mem [MAX_ENTRIES];
  logic [CW+lz78_pkg::BYTE_W-1:0] rdata_r;
  logic          mem_we;
  logic [XW-1:0] lim_eff, cnt1;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (limit_r == '0 || XW'(limit_r) > MAXX) lim_eff = MAXX;
    else lim_eff = XW'(limit_r);
    cnt1 = (XW'(count_r) < MAXX) ? XW'(count_r) + XW'(1) : XW'(count_r);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    prefix_nxt    = prefix_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (count_r == '0) ? ST_FIN : ST_RD;
        end
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (rdata_r == {prefix_r, item_r.in_byte}) begin
          found_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else if (idx_r + CW'(1) == count_r) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        // result register must be free before committing
        if (!(out_valid_r && out_stall)) begin
          state_nxt = ST_IDLE;
          if (found_r) begin
            prefix_nxt = idx_r + CW'(1);
            if (item_r.last) begin
              out_nxt       = '{code: lz78_pkg::CODE_W'(idx_r + CW'(1)),
                                out_byte: '0, has_byte: 1'b0};
              out_valid_nxt = 1'b1;
            end
          end else begin
            out_nxt       = '{code: lz78_pkg::CODE_W'(prefix_r),
                              out_byte: item_r.in_byte, has_byte: 1'b1};
            out_valid_nxt = 1'b1;
            mem_we        = (XW'(count_r) < MAXX);
            prefix_nxt    = '0;
            count_nxt     = (cnt1 >= lim_eff) ? '0 : CW'(cnt1);
          end
          if (item_r.last) begin
            count_nxt  = '0;
            prefix_nxt = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      prefix_r    <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= lz78_pkg::LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prefix_r    <= prefix_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == ST_IDLE && in_valid) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[AW-1:0]] <= {prefix_r, item_r.in_byte};
    rdata_r <= mem[idx_r[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_prefix_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_r <= count_r) else $error("prefix beyond entry count");
  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= MAXX) else $error("entry count beyond capacity");
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> idx_r < count_r) else $error("probe past last entry");
`endif
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// testbench for lz78_encoder: byte streams in, phrase tokens out, checked against
// a phrase-table predictor kept in a small scoreboard class; depends on lz78_pkg
`timescale 1ns / 100ps
module testbench;

  localparam int DICT_SIZE = 4096;
  localparam int LONG_HOLD = 400;

  class phrase_book;
    logic [12:0] parent_of [DICT_SIZE];
    logic [7:0]  key_of [DICT_SIZE];
    int unsigned count;
    logic [12:0] prefix = '0;
    logic [12:0] limit;
    lz78_pkg::out_item_t tokens [$];
    int unsigned errors;

    function void set_limit(logic [12:0] value);
      limit = value;
    endfunction

    function int unsigned eff_limit();
      if (limit == 0 || limit > DICT_SIZE) return DICT_SIZE;
      return limit;
    endfunction

    // an accepted input byte: walk the table and queue the token it causes
    function void take_byte(lz78_pkg::in_item_t item);
      int unsigned hit;
      lz78_pkg::out_item_t tok;
      hit = 0;
      for (int i = 0; i < count; i++)
        if (parent_of[i] == prefix && key_of[i] == item.in_byte) begin
          hit = i + 1;
          break;
        end
      if (hit != 0) begin
        prefix = hit[12:0];
        if (item.last) begin
          tok.code = hit[15:0];
          tok.out_byte = '0;
          tok.has_byte = 1'b0;
          tokens.push_back(tok);
        end
      end else begin
        tok.code = {3'b0, prefix};
        tok.out_byte = item.in_byte;
        tok.has_byte = 1'b1;
        tokens.push_back(tok);
        if (count < DICT_SIZE) begin
          parent_of[count] = prefix;
          key_of[count] = item.in_byte;
          count++;
        end
        prefix = '0;
        if (count >= eff_limit()) count = 0;
      end
      if (item.last) begin
        count = 0;
        prefix = '0;
      end
    endfunction

    function void check_token(lz78_pkg::out_item_t got);
      lz78_pkg::out_item_t want;
      if (tokens.size() == 0) begin
        $error("unexpected token code=%0d byte=%0d has_byte=%0d",
               got.code, got.out_byte, got.has_byte);
        errors++;
        return;
      end
      want = tokens.pop_front();
      if (got.code !== want.code) begin
        $error("code: expected %0d, got %0d", want.code, got.code);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %0d, got %0d", want.has_byte, got.has_byte);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  lz78_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lz78_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;

  phrase_book book;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 0;
  int  hold_left = 0;

  lz78_encoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) book.take_byte(in_data);
    if (rst_n && out_valid && !out_stall) book.check_token(out_data);
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = LONG_HOLD;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(logic [7:0] b, logic l);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, last: l};
    do @(posedge clk); while (in_stall);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (book.tokens.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    book.set_limit(value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // byte from a narrow alphabet most of the time so that phrases repeat
  function automatic logic [7:0] pick_byte(int alpha);
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(alpha - 1));
  endfunction

  // streams of random length, each closed by a last item
  task automatic run_streams(int n_items);
    int sent, len, alpha;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? 1 : $urandom_range(60, 2);
      alpha = $urandom_range(6, 2);
      for (int i = 0; i < len; i++)
        send_item(pick_byte(alpha), i == len - 1);
      sent += len;
    end
  endtask

  task automatic set_mode(int m);
    case (m % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 82; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 82; end
      default: begin idle_pct = 9; stall_pct = 9; end
    endcase
  endtask

  initial begin
    logic [12:0] limits [10] = '{13'd1, 13'd2, 13'd0, 13'd8191, 13'd5000,
                                 13'd4096, 13'd3, 13'd4097, 13'd7, 13'd16};
    book = new();
    book.set_limit(lz78_pkg::LIMIT_RESET);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: repeats, last matched, last unmatched, single-byte stream, extremes
    send_item(8'd0, 1'b0);   send_item(8'd0, 1'b0);   send_item(8'd0, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd255, 1'b1);
    send_item(8'd255, 1'b0); send_item(8'd255, 1'b0); send_item(8'd255, 1'b0);
    send_item(8'd170, 1'b1);
    send_item(8'd85, 1'b0);  send_item(8'd85, 1'b0);  send_item(8'd85, 1'b1);
    drain();
    repeat (20) @(posedge clk);

    for (int p = 0; p < 10; p++) begin
      write_limit(limits[p]);
      set_mode(p);
      run_streams(100);
      drain();
      repeat (20) @(posedge clk);
    end

    // fill under the full limit, then lower the limit below the entry count
    write_limit(13'd4096);
    set_mode(0);
    for (int i = 0; i < 30; i++) send_item(pick_byte(8), 1'b0);
    drain();
    repeat (2 * DICT_SIZE + 20) @(posedge clk);
    write_limit(13'd5);
    set_mode(3);
    for (int i = 0; i < 20; i++) send_item(pick_byte(4), 1'b0);
    send_item(8'd9, 1'b1);

    // receiver holds off while the sender keeps offering items
    set_mode(0);
    hold_go = 1;
    for (int i = 0; i < 40; i++) send_item(pick_byte(3), i == 39);
    drain();
    repeat (20) @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      write_limit(13'($urandom_range(64, 1)));
      set_mode(p);
      run_streams(40);
      drain();
      repeat (20) @(posedge clk);
    end

    drain();
    repeat (50) @(posedge clk);
    if (book.errors == 0 && book.tokens.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
